@@ src/ppb_pkg.sv @@
// ----------------------------------------------------------------------------
// ppb_pkg: shared types and constants for perspective_projection_bounds
// Coordinate width, derived datapath widths, register indexes and the
// sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package ppb_pkg;

  localparam int COORD_BITS = 16;

  // register widths
  localparam int DIST_W = 15;
  localparam int WIN_W  = 14;
  localparam int CFG_W  = 15;
  localparam int IDX_W  = 2;

  // signed product coord * distance
  localparam int PROD_W = COORD_BITS + DIST_W + 1;
  // product magnitude
  localparam int MAG_W  = COORD_BITS + DIST_W;
  // signed denominator z + distance, also used for its magnitude
  localparam int DEN_W  = ((COORD_BITS > DIST_W) ? COORD_BITS : DIST_W) + 2;
  // signed width for center add and saturation, at least 33 bits
  localparam int SUM_W  = ((MAG_W + 2) > 33) ? (MAG_W + 2) : 33;
  localparam int CNT_W  = $clog2(MAG_W);

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);

  localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;
  localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-32){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-32){1'b1}}, 32'h8000_0000};

  // register indexes
  localparam logic [IDX_W-1:0] REG_CAMERA_DISTANCE = 2'd0;
  localparam logic [IDX_W-1:0] REG_WINDOW_WIDTH    = 2'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_HEIGHT   = 2'd2;

  localparam logic [DIST_W-1:0] CAMERA_DISTANCE_RST = 15'd1000;
  localparam logic [WIN_W-1:0]  WINDOW_WIDTH_RST    = 14'd1920;
  localparam logic [WIN_W-1:0]  WINDOW_HEIGHT_RST   = 14'd1080;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEN,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } ppb_state_t;

endpackage

`default_nettype wire

@@ src/perspective_projection_bounds.sv @@
// Datapath: one shared restoring divider is run once for x and once for y,
// one quotient bit per cycle. Zero-depth transactions skip the multiply and
// divide steps. in_ready is high only when idle, so a new transaction is taken
// only after the previous result has been moved to the output registers.
// Reset (rst_n, synchronous): registers to defaults, bounds to empty extremes.
// ----------------------------------------------------------------------------
// perspective_projection_bounds
// Perspective projection of one vertex per transaction with running
// min/max screen bounds and a zero-depth error flag.
// ----------------------------------------------------------------------------
`default_nettype none

module perspective_projection_bounds (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [ppb_pkg::IDX_W-1:0]           cfg_index,
  input  wire logic [ppb_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [ppb_pkg::COORD_BITS-1:0] in_vertex_x,
  input  wire logic signed [ppb_pkg::COORD_BITS-1:0] in_vertex_y,
  input  wire logic signed [ppb_pkg::COORD_BITS-1:0] in_vertex_z,
  input  wire logic                                in_first_point,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [31:0]                       out_screen_x,
  output logic signed [31:0]                       out_screen_y,
  output logic signed [31:0]                       out_least_x,
  output logic signed [31:0]                       out_greatest_x,
  output logic signed [31:0]                       out_least_y,
  output logic signed [31:0]                       out_greatest_y,
  output logic                                     out_zero_depth_error
);

  localparam int CB  = ppb_pkg::COORD_BITS;
  localparam int DW  = ppb_pkg::DIST_W;
  localparam int WW  = ppb_pkg::WIN_W;
  localparam int PW  = ppb_pkg::PROD_W;
  localparam int MW  = ppb_pkg::MAG_W;
  localparam int NW  = ppb_pkg::DEN_W;
  localparam int SW  = ppb_pkg::SUM_W;
  localparam int CW  = ppb_pkg::CNT_W;

  ppb_pkg::ppb_state_t state_r, state_nxt;

  logic [DW-1:0] dist_r, dist_nxt;
  logic [WW-1:0] win_w_r, win_w_nxt;
  logic [WW-1:0] win_h_r, win_h_nxt;

  logic signed [CB-1:0] vx_r, vx_nxt, vy_r, vy_nxt, vz_r, vz_nxt;
  logic first_r, first_nxt;
  logic err_r, err_nxt;
  logic sel_y_r, sel_y_nxt;
  logic den_neg_r, den_neg_nxt;
  logic q_neg_r, q_neg_nxt;
  logic [NW-1:0] den_mag_r, den_mag_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic [MW-1:0] quo_r, quo_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [31:0] sx_r, sx_nxt, sy_r, sy_nxt;

  logic signed [31:0] lox_r, lox_nxt, hix_r, hix_nxt, loy_r, loy_nxt, hiy_r, hiy_nxt;

  logic out_valid_r, out_valid_nxt;
  logic signed [31:0] o_sx_r, o_sx_nxt, o_sy_r, o_sy_nxt;
  logic signed [31:0] o_lox_r, o_lox_nxt, o_hix_r, o_hix_nxt;
  logic signed [31:0] o_loy_r, o_loy_nxt, o_hiy_r, o_hiy_nxt;
  logic o_err_r, o_err_nxt;

  // combinational datapath
  logic signed [NW-1:0] denom;
  logic signed [CB-1:0] coord;
  logic [PW-1:0] prod_mag;
  logic [NW:0] rem_sh, diff;
  logic quo_bit;
  logic signed [SW-1:0] q_ext, q_val, sum, half_ext;
  logic signed [31:0] sat;
  logic [WW-1:0] half_win;
  logic signed [31:0] b_lox, b_hix, b_loy, b_hiy;
  logic signed [31:0] c_lox, c_hix, c_loy, c_hiy;

  assign in_ready = (state_r == ppb_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    dist_nxt      = dist_r;
    win_w_nxt     = win_w_r;
    win_h_nxt     = win_h_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    vz_nxt        = vz_r;
    first_nxt     = first_r;
    err_nxt       = err_r;
    sel_y_nxt     = sel_y_r;
    den_neg_nxt   = den_neg_r;
    q_neg_nxt     = q_neg_r;
    den_mag_nxt   = den_mag_r;
    prod_nxt      = prod_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    lox_nxt       = lox_r;
    hix_nxt       = hix_r;
    loy_nxt       = loy_r;
    hiy_nxt       = hiy_r;
    out_valid_nxt = out_valid_r;
    o_sx_nxt      = o_sx_r;
    o_sy_nxt      = o_sy_r;
    o_lox_nxt     = o_lox_r;
    o_hix_nxt     = o_hix_r;
    o_loy_nxt     = o_loy_r;
    o_hiy_nxt     = o_hiy_r;
    o_err_nxt     = o_err_r;

    denom = $signed({{(NW-CB){vz_r[CB-1]}}, vz_r}) + $signed({{(NW-DW){1'b0}}, dist_r});
    coord = sel_y_r ? vy_r : vx_r;
    prod_mag = prod_r[PW-1] ? PW'(-prod_r) : prod_r;
    rem_sh = {rem_r, quo_r[MW-1]};
    diff = rem_sh - {1'b0, den_mag_r};
    quo_bit = ~diff[NW];
    q_ext = $signed({{(SW-MW){1'b0}}, quo_r});
    q_val = q_neg_r ? -q_ext : q_ext;
    half_win = sel_y_r ? (win_h_r >> 1) : (win_w_r >> 1);
    half_ext = $signed({{(SW-WW){1'b0}}, half_win});
    sum = q_val + half_ext;
    if (sum > ppb_pkg::SAT_HI) begin
      sat = ppb_pkg::INT32_MAX;
    end else if (sum < ppb_pkg::SAT_LO) begin
      sat = ppb_pkg::INT32_MIN;
    end else begin
      sat = sum[31:0];
    end

    b_lox = first_r ? ppb_pkg::INT32_MAX : lox_r;
    b_hix = first_r ? ppb_pkg::INT32_MIN : hix_r;
    b_loy = first_r ? ppb_pkg::INT32_MAX : loy_r;
    b_hiy = first_r ? ppb_pkg::INT32_MIN : hiy_r;
    c_lox = (sx_r < b_lox) ? sx_r : b_lox;
    c_hix = (sx_r > b_hix) ? sx_r : b_hix;
    c_loy = (sy_r < b_loy) ? sy_r : b_loy;
    c_hiy = (sy_r > b_hiy) ? sy_r : b_hiy;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        ppb_pkg::REG_CAMERA_DISTANCE: dist_nxt  = cfg_data[DW-1:0];
        ppb_pkg::REG_WINDOW_WIDTH:    win_w_nxt = cfg_data[WW-1:0];
        ppb_pkg::REG_WINDOW_HEIGHT:   win_h_nxt = cfg_data[WW-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ppb_pkg::ST_IDLE: begin
        if (in_valid) begin
          vx_nxt    = in_vertex_x;
          vy_nxt    = in_vertex_y;
          vz_nxt    = in_vertex_z;
          first_nxt = in_first_point;
          state_nxt = ppb_pkg::ST_DEN;
        end
      end
      ppb_pkg::ST_DEN: begin
        err_nxt     = (denom == '0);
        den_neg_nxt = denom[NW-1];
        den_mag_nxt = denom[NW-1] ? NW'(-denom) : denom;
        sel_y_nxt   = 1'b0;
        if (denom == '0) begin
          sx_nxt    = '0;
          sy_nxt    = '0;
          state_nxt = ppb_pkg::ST_DONE;
        end else begin
          state_nxt = ppb_pkg::ST_MUL;
        end
      end
      ppb_pkg::ST_MUL: begin
        prod_nxt  = coord * $signed({1'b0, dist_r});
        state_nxt = ppb_pkg::ST_LOAD;
      end
      ppb_pkg::ST_LOAD: begin
        quo_nxt   = prod_mag[MW-1:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        q_neg_nxt = prod_r[PW-1] ^ den_neg_r;
        state_nxt = ppb_pkg::ST_DIV;
      end
      ppb_pkg::ST_DIV: begin
        rem_nxt = quo_bit ? diff[NW-1:0] : rem_sh[NW-1:0];
        quo_nxt = {quo_r[MW-2:0], quo_bit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ppb_pkg::DIV_LAST) begin
          state_nxt = ppb_pkg::ST_FIX;
        end
      end
      ppb_pkg::ST_FIX: begin
        if (sel_y_r) begin
          sy_nxt    = sat;
          state_nxt = ppb_pkg::ST_DONE;
        end else begin
          sx_nxt    = sat;
          sel_y_nxt = 1'b1;
          state_nxt = ppb_pkg::ST_MUL;
        end
      end
      ppb_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_sx_nxt      = sx_r;
          o_sy_nxt      = sy_r;
          o_err_nxt     = err_r;
          if (err_r) begin
            o_lox_nxt = lox_r;
            o_hix_nxt = hix_r;
            o_loy_nxt = loy_r;
            o_hiy_nxt = hiy_r;
          end else begin
            lox_nxt   = c_lox;
            hix_nxt   = c_hix;
            loy_nxt   = c_loy;
            hiy_nxt   = c_hiy;
            o_lox_nxt = c_lox;
            o_hix_nxt = c_hix;
            o_loy_nxt = c_loy;
            o_hiy_nxt = c_hiy;
          end
          state_nxt = ppb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ppb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppb_pkg::ST_IDLE;
      dist_r      <= ppb_pkg::CAMERA_DISTANCE_RST;
      win_w_r     <= ppb_pkg::WINDOW_WIDTH_RST;
      win_h_r     <= ppb_pkg::WINDOW_HEIGHT_RST;
      lox_r       <= ppb_pkg::INT32_MAX;
      hix_r       <= ppb_pkg::INT32_MIN;
      loy_r       <= ppb_pkg::INT32_MAX;
      hiy_r       <= ppb_pkg::INT32_MIN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dist_r      <= dist_nxt;
      win_w_r     <= win_w_nxt;
      win_h_r     <= win_h_nxt;
      lox_r       <= lox_nxt;
      hix_r       <= hix_nxt;
      loy_r       <= loy_nxt;
      hiy_r       <= hiy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vx_r      <= vx_nxt;
    vy_r      <= vy_nxt;
    vz_r      <= vz_nxt;
    first_r   <= first_nxt;
    err_r     <= err_nxt;
    sel_y_r   <= sel_y_nxt;
    den_neg_r <= den_neg_nxt;
    q_neg_r   <= q_neg_nxt;
    den_mag_r <= den_mag_nxt;
    prod_r    <= prod_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    o_sx_r    <= o_sx_nxt;
    o_sy_r    <= o_sy_nxt;
    o_lox_r   <= o_lox_nxt;
    o_hix_r   <= o_hix_nxt;
    o_loy_r   <= o_loy_nxt;
    o_hiy_r   <= o_hiy_nxt;
    o_err_r   <= o_err_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_screen_x         = o_sx_r;
  assign out_screen_y         = o_sy_r;
  assign out_least_x          = o_lox_r;
  assign out_greatest_x       = o_hix_r;
  assign out_least_y          = o_loy_r;
  assign out_greatest_y       = o_hiy_r;
  assign out_zero_depth_error = o_err_r;

endmodule

`default_nettype wire
